[hdl/oil_pkg.sv]
package oil_pkg;
    localparam int LIST_DEPTH = 256;
    localparam int AW = $clog2(LIST_DEPTH);
    localparam int LW = AW + 1;

    localparam logic [3:0] OP_ADVANCE  = 4'd0;
    localparam logic [3:0] OP_CUR_ID   = 4'd1;
    localparam logic [3:0] OP_CUR_POS  = 4'd2;
    localparam logic [3:0] OP_APPEND   = 4'd3;
    localparam logic [3:0] OP_INSERT   = 4'd4;
    localparam logic [3:0] OP_REMOVE   = 4'd5;
    localparam logic [3:0] OP_REMOVE_ID = 4'd6;
    localparam logic [3:0] OP_MOVE     = 4'd7;
    localparam logic [3:0] OP_SET_POS  = 4'd8;
    localparam logic [3:0] OP_SET_REL  = 4'd9;
    localparam logic [3:0] OP_CLEAR    = 4'd10;
    localparam logic [3:0] OP_READ_AT  = 4'd11;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_RANGE = 3'd1;
    localparam logic [2:0] ST_ZERO  = 3'd2;
    localparam logic [2:0] ST_NOCUR = 3'd3;
    localparam logic [2:0] ST_FULL  = 3'd4;

    localparam logic CFG_REPEAT_ONE = 1'b0;
    localparam logic CFG_REPEAT_ALL = 1'b1;
endpackage

[hdl/ordered_id_list_with_cursor.sv]
// Channel | dir | tdata (low bit up)                                  | tuser
// s_      | in  | opcode[3:0] position[11:4] new_position[19:12]
//         |     | offset[28:20] entry_id[60:29], zero pad to 64       | -
// m_      | out | ok[0] status[3:1] result_id[35:4] cursor[44:36], pad | -
// cfg_    | in  | cfg_index selects register, cfg_data bit 0 is value | -
// One memory step runs through the states read, wait and use/write. Ops without a step go
// straight to the result, and reads take one step. Insert and remove at p take one step per entry
// from p to the end of the list; move takes a drop pass from p and a put pass from np. Remove-id
// takes one step per scanned entry and per shifted id, rescanning from each hole it closes.
// Reset (aresetn low, synchronous) empties the list and clears the cursor to -1.
// s_tready is low while an op runs or while its result waits on m_tready.
module ordered_id_list_with_cursor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // opcode, position, new_position, offset, entry_id
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // ok, status, result_id, cursor
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [0:0]  cfg_data
);
    import oil_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;  // issue read at idx
    localparam logic [2:0] S_WAIT = 3'd2;  // memory read data lands
    localparam logic [2:0] S_WR   = 3'd3;  // use read data, write
    localparam logic [2:0] S_OUT  = 3'd4;

    localparam logic [1:0] PH_FIRST = 2'd0;
    localparam logic [1:0] PH_DROP  = 2'd1;
    localparam logic [1:0] PH_PUT   = 2'd2;

    logic [31:0] mem [LIST_DEPTH];
    logic [31:0] rdata_reg;

    logic [2:0]  state_reg, state_next;
    logic [LW-1:0] len_reg, len_next;
    logic signed [LW:0] cur_reg, cur_next;
    logic rep_one_reg, rep_all_reg;

    logic [3:0]  op_reg;
    logic [AW-1:0] pos_reg, npos_reg;
    logic [31:0] eid_reg, eid_next;
    logic [LW-1:0] idx_reg, idx_next;   // walking index
    logic [31:0] carry_reg, carry_next;
    logic        ok_reg, ok_next;
    logic [2:0]  st_reg, st_next;
    logic [31:0] rid_reg, rid_next;
    logic [1:0]  phase_reg, phase_next; // first read, drop, put

    logic        we;
    logic [AW-1:0] waddr, raddr;
    logic [31:0] wdata;

    logic [3:0]  in_op;
    logic [AW-1:0] in_pos, in_npos;
    logic signed [8:0] in_ofs;
    logic [31:0] in_eid;
    logic signed [LW+1:0] rel_t;

    assign in_op   = s_tdata[3:0];
    assign in_pos  = s_tdata[11:4];
    assign in_npos = s_tdata[19:12];
    assign in_ofs  = s_tdata[28:20];
    assign in_eid  = s_tdata[60:29];

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = (state_reg == S_OUT);
    assign m_tdata   = {3'd0, cur_reg[8:0], rid_reg, st_reg, ok_reg};

    assign rel_t = $signed({cur_reg[LW], cur_reg}) + in_ofs;

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    always_comb begin
        state_next = state_reg;
        len_next   = len_reg;
        cur_next   = cur_reg;
        eid_next   = eid_reg;
        idx_next   = idx_reg;
        carry_next = carry_reg;
        ok_next    = ok_reg;
        st_next    = st_reg;
        rid_next   = rid_reg;
        phase_next = phase_reg;
        we    = 1'b0;
        waddr = idx_reg[AW-1:0];
        wdata = carry_reg;
        raddr = idx_reg[AW-1:0];
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    ok_next  = 1'b0;
                    st_next  = ST_OK;
                    rid_next = '0;
                    eid_next = in_eid;
                    phase_next = PH_FIRST;
                    state_next = S_OUT;
                    case (in_op)
                        OP_ADVANCE: begin
                            if (len_reg == 0) st_next = ST_NOCUR;
                            else if (rep_one_reg) ok_next = 1'b1;
                            else begin
                                if (cur_reg + 1 >= $signed({1'b0, len_reg})) begin
                                    cur_next = '0;
                                    ok_next  = rep_all_reg;
                                end else begin
                                    cur_next = (LW+1)'(cur_reg + 1);
                                    // landing on entry 0 from no cursor counts as a wrap
                                    ok_next  = (cur_reg >= 0) || rep_all_reg;
                                end
                            end
                        end
                        OP_CUR_ID: begin
                            if (len_reg == 0 || cur_reg >= $signed({1'b0, len_reg}))
                                st_next = ST_NOCUR;
                            else begin
                                if (cur_reg < 0) cur_next = '0;
                                idx_next = (cur_reg < 0) ? '0 : cur_reg[LW-1:0];
                                state_next = S_RD;
                            end
                        end
                        OP_CUR_POS: begin
                            if (cur_reg < 0) st_next = ST_NOCUR; else ok_next = 1'b1;
                        end
                        OP_APPEND: begin
                            if (in_eid == 0) st_next = ST_ZERO;
                            else if (len_reg >= LW'(LIST_DEPTH)) st_next = ST_FULL;
                            else begin
                                we = 1'b1; waddr = len_reg[AW-1:0]; wdata = in_eid;
                                len_next = len_reg + 1'b1;
                                ok_next = 1'b1;
                            end
                        end
                        OP_INSERT: begin
                            if (in_eid == 0) st_next = ST_ZERO;
                            else if (LW'(in_pos) > ((len_reg == 0) ? '0 : len_reg - 1'b1))
                                st_next = ST_RANGE;
                            else if (len_reg >= LW'(LIST_DEPTH)) st_next = ST_FULL;
                            else begin
                                // ripple forward from pos, carrying displaced id
                                carry_next = in_eid;
                                idx_next = LW'(in_pos);
                                state_next = S_RD;
                                ok_next = 1'b1;
                            end
                        end
                        OP_REMOVE: begin
                            if (LW'(in_pos) >= len_reg) st_next = ST_RANGE;
                            else begin
                                idx_next = LW'(in_pos);
                                state_next = S_RD;
                                ok_next = 1'b1;
                            end
                        end
                        OP_REMOVE_ID: begin
                            ok_next = 1'b1;
                            idx_next = '0;
                            state_next = S_RD;
                        end
                        OP_MOVE: begin
                            if (LW'(in_npos) >= len_reg || LW'(in_pos) >= len_reg)
                                st_next = ST_RANGE;
                            else begin
                                idx_next = LW'(in_pos);
                                state_next = S_RD;
                                ok_next = 1'b1;
                            end
                        end
                        OP_SET_POS: begin
                            if (LW'(in_pos) >= len_reg) st_next = ST_RANGE;
                            else begin
                                cur_next = $signed({2'b0, in_pos});
                                idx_next = LW'(in_pos);
                                state_next = S_RD;
                            end
                        end
                        OP_SET_REL: begin
                            if (rel_t < 0 || rel_t >= $signed({2'b0, len_reg}))
                                st_next = ST_RANGE;
                            else begin
                                cur_next = rel_t[LW:0];
                                idx_next = rel_t[LW-1:0];
                                state_next = S_RD;
                            end
                        end
                        OP_CLEAR: begin
                            len_next = '0;
                            cur_next = '1;
                            ok_next = 1'b1;
                        end
                        OP_READ_AT: begin
                            if (LW'(in_pos) >= len_reg) st_next = ST_RANGE;
                            else begin
                                idx_next = LW'(in_pos);
                                state_next = S_RD;
                            end
                        end
                        default: st_next = ST_RANGE;
                    endcase
                end
            end
            S_RD: begin
                state_next = S_WAIT;
            end
            S_WAIT: begin
                state_next = S_WR;
            end
            S_WR: begin
                state_next = S_RD;
                case (op_reg)
                    OP_CUR_ID, OP_SET_POS, OP_SET_REL, OP_READ_AT: begin
                        rid_next = rdata_reg;
                        ok_next = 1'b1;
                        state_next = S_OUT;
                    end
                    OP_INSERT: begin
                        // write carry at idx, carry old id onward
                        we = 1'b1;
                        carry_next = rdata_reg;
                        if (idx_reg == len_reg) begin
                            len_next = len_reg + 1'b1;
                            state_next = S_OUT;
                        end else idx_next = idx_reg + 1'b1;
                    end
                    OP_REMOVE, OP_REMOVE_ID, OP_MOVE: begin
                        // first read or id scan, then drop phase (hole at idx-1, pull idx down), then put for move
                        if (op_reg == OP_REMOVE_ID && phase_reg == PH_FIRST) begin
                            if (idx_reg >= len_reg) state_next = S_OUT;
                            else if (rdata_reg == eid_reg) begin
                                phase_next = PH_DROP;
                                if (cur_reg >= 0 && $signed({1'b0, idx_reg}) <= cur_reg)
                                    cur_next = (LW+1)'(cur_reg - 1);
                                carry_next = 32'(idx_reg); // remember hole start
                                idx_next = idx_reg + 1'b1;
                            end else idx_next = idx_reg + 1'b1;
                        end else if (op_reg == OP_MOVE && phase_reg == PH_PUT) begin
                            we = 1'b1;
                            carry_next = rdata_reg;
                            if (idx_reg == len_reg - 1'b1) state_next = S_OUT;
                            else idx_next = idx_reg + 1'b1;
                        end else if (phase_reg == PH_FIRST && op_reg != OP_REMOVE_ID) begin
                            phase_next = PH_DROP;
                            if (op_reg == OP_MOVE) eid_next = rdata_reg;
                            idx_next = idx_reg + 1'b1;
                        end else begin
                            // shifting: read was at idx, write to idx-1
                            if (idx_reg >= len_reg) begin
                                len_next = len_reg - 1'b1;
                                if (op_reg == OP_REMOVE) begin
                                    if (cur_reg >= 0 && $signed({2'b0, pos_reg}) <= cur_reg)
                                        cur_next = (LW+1)'(cur_reg - 1);
                                    state_next = S_OUT;
                                end else if (op_reg == OP_REMOVE_ID) begin
                                    phase_next = PH_FIRST;
                                    idx_next = carry_reg[LW-1:0];
                                end else begin
                                    // move: start put phase at npos
                                    phase_next = PH_PUT;
                                    carry_next = eid_reg;
                                    idx_next = LW'(npos_reg);
                                    len_next = len_reg;
                                    if (cur_reg >= 0) begin
                                        if (npos_reg <= cur_reg[AW-1:0] && pos_reg > cur_reg[AW-1:0])
                                            cur_next = (LW+1)'(cur_reg + 1);
                                        else if (npos_reg >= cur_reg[AW-1:0] &&
                                                 pos_reg < cur_reg[AW-1:0])
                                            cur_next = (LW+1)'(cur_reg - 1);
                                        else if (pos_reg == cur_reg[AW-1:0])
                                            cur_next = $signed({2'b0, npos_reg});
                                    end
                                end
                            end else begin
                                we = 1'b1;
                                waddr = AW'(idx_reg - 1'b1);
                                wdata = rdata_reg;
                                idx_next = idx_reg + 1'b1;
                            end
                        end
                    end
                    default: state_next = S_OUT;
                endcase
            end
            S_OUT: begin
                if (m_tready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            len_reg <= '0;
            cur_reg <= '1;
            rep_one_reg <= 1'b0;
            rep_all_reg <= 1'b0;
            phase_reg <= PH_FIRST;
        end else begin
            state_reg <= state_next;
            len_reg <= len_next;
            cur_reg <= cur_next;
            phase_reg <= phase_next;
            if (cfg_valid) begin
                if (cfg_index == CFG_REPEAT_ONE) rep_one_reg <= cfg_data[0];
                if (cfg_index == CFG_REPEAT_ALL) rep_all_reg <= cfg_data[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE) begin
            op_reg <= in_op;
            pos_reg <= in_pos;
            npos_reg <= in_npos;
        end
        eid_reg <= eid_next;
        idx_reg <= idx_next;
        carry_reg <= carry_next;
        ok_reg <= ok_next;
        st_reg <= st_next;
        rid_reg <= rid_next;
    end
endmodule

[hdl/oil_checker.sv]
module oil_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);
    import oil_pkg::*;

    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("input open while result pending");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped");
    a_okst: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[3:1] == ST_OK)
        else $error("ok with error status");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready) else $error("ready during op");
endmodule

bind ordered_id_list_with_cursor oil_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

[dv/tb_ordered_id_list_with_cursor.sv]
module tb_ordered_id_list_with_cursor;
    import oil_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [0:0]  cfg_data = 1'b0;

    typedef struct packed {
        logic [3:0]  opcode;
        logic [7:0]  position;
        logic [7:0]  new_position;
        logic [8:0]  offset;
        logic [31:0] entry_id;
    } op_t;

    typedef struct packed {
        logic              ok;
        logic [2:0]        status;
        logic [31:0]       result_id;
        logic signed [8:0] cursor;
    } reply_t;

    typedef struct {
        op_t    op;
        logic   known;
        reply_t want;
    } row_t;

    ordered_id_list_with_cursor dut (.*);

    always #4 aclk = ~aclk;

    // shadow of the list
    logic [31:0] ids [LIST_DEPTH];
    int          len;
    int          cur;
    logic        rep_one, rep_all;

    reply_t      pending_replies [$];
    int          errors = 0;
    int          cycles = 0;
    int          src_idle = 0, dst_idle = 0;
    row_t        rows [$];

    function automatic logic [63:0] pack_op(op_t o);
        return {3'b0, o.entry_id, o.offset, o.new_position, o.position, o.opcode};
    endfunction

    function automatic op_t mk(logic [3:0] opc, logic [7:0] p, logic [7:0] np,
                               logic [8:0] ofs, logic [31:0] id);
        op_t o;
        o.opcode = opc; o.position = p; o.new_position = np;
        o.offset = ofs; o.entry_id = id;
        return o;
    endfunction

    task automatic drop_id(int p);
        for (int i = p; i + 1 < len; i++) ids[i] = ids[i + 1];
        len--;
    endtask

    task automatic put_id(int p, logic [31:0] id);
        for (int i = len; i > p; i--) ids[i] = ids[i - 1];
        ids[p] = id;
        len++;
    endtask

    task automatic list_step(input op_t o, output reply_t r);
        int p, np, t, sp, lim, i;
        logic [31:0] mv;
        p = o.position; np = o.new_position;
        r.ok = 0; r.status = ST_OK; r.result_id = '0;
        case (o.opcode)
            OP_ADVANCE: begin
                if (len == 0) r.status = ST_NOCUR;
                else if (rep_one) r.ok = 1;
                else begin
                    cur = (cur + 1) % len;
                    r.ok = (cur != 0 || rep_all);
                end
            end
            OP_CUR_ID: begin
                if (cur == -1 && len > 0) cur = 0;
                if (cur >= 0 && cur < len) begin r.result_id = ids[cur]; r.ok = 1; end
                else r.status = ST_NOCUR;
            end
            OP_CUR_POS: if (cur == -1) r.status = ST_NOCUR; else r.ok = 1;
            OP_APPEND: begin
                if (o.entry_id == 0) r.status = ST_ZERO;
                else if (len >= LIST_DEPTH) r.status = ST_FULL;
                else begin ids[len] = o.entry_id; len++; r.ok = 1; end
            end
            OP_INSERT: begin
                lim = len ? len - 1 : 0;
                if (o.entry_id == 0) r.status = ST_ZERO;
                else if (p > lim) r.status = ST_RANGE;
                else if (len >= LIST_DEPTH) r.status = ST_FULL;
                else begin put_id(p, o.entry_id); r.ok = 1; end
            end
            OP_REMOVE: begin
                if (p >= len) r.status = ST_RANGE;
                else begin
                    drop_id(p);
                    if (cur != -1 && p <= cur) cur--;
                    r.ok = 1;
                end
            end
            OP_REMOVE_ID: begin
                i = 0;
                while (i < len) begin
                    if (ids[i] == o.entry_id) begin
                        drop_id(i);
                        if (cur != -1 && i <= cur) cur--;
                    end else i++;
                end
                r.ok = 1;
            end
            OP_MOVE: begin
                if (len == 0 || np >= len || p >= len) r.status = ST_RANGE;
                else begin
                    mv = ids[p]; sp = p;
                    drop_id(p);
                    put_id(np, mv);
                    if (cur != -1) begin
                        if (np <= cur && sp > cur) cur++;
                        else if (np >= cur && sp < cur) cur--;
                        else if (sp == cur) cur = np;
                    end
                    r.ok = 1;
                end
            end
            OP_SET_POS: begin
                if (p >= len) r.status = ST_RANGE;
                else begin cur = p; r.result_id = ids[p]; r.ok = 1; end
            end
            OP_SET_REL: begin
                t = cur + $signed(o.offset);
                if (t < 0 || t >= len) r.status = ST_RANGE;
                else begin cur = t; r.result_id = ids[t]; r.ok = 1; end
            end
            OP_CLEAR: begin len = 0; cur = -1; r.ok = 1; end
            OP_READ_AT: begin
                if (p >= len) r.status = ST_RANGE;
                else begin r.result_id = ids[p]; r.ok = 1; end
            end
            default: r.status = ST_RANGE;
        endcase
        r.cursor = cur[8:0];
    endtask

    task automatic send_op(input op_t o, input logic known, input reply_t want);
        reply_t r;
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata  <= pack_op(o);
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        list_step(o, r);
        if (known && r !== want) begin
            errors++;
            if (errors <= 10)
                $display("directed row mismatch: table %h predictor %h", want, r);
        end
        pending_replies.push_back(r);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(negedge aclk);
        repeat (2 * LIST_DEPTH + 20) @(negedge aclk);
    endtask

    task automatic write_reg(logic idx, logic val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_REPEAT_ONE) rep_one = val; else rep_all = val;
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic op_t rand_op();
        op_t o;
        int k;
        o = mk(4'($urandom_range(15)), '0, '0, '0, '0);
        k = $urandom_range(99);
        if (k < 90 && o.opcode > OP_READ_AT) o.opcode = 4'($urandom_range(11));
        if (k < 30 && o.opcode == OP_CLEAR) o.opcode = OP_APPEND;
        o.position     = (len > 0 && k < 85) ? 8'($urandom_range(len)) : 8'($urandom_range(255));
        o.new_position = (len > 0 && k < 85) ? 8'($urandom_range(len)) : 8'($urandom_range(255));
        o.offset       = k < 70 ? 9'($urandom_range(8) - 4) : 9'($urandom_range(511));
        case ($urandom_range(3))
            0: o.entry_id = 32'($urandom_range(1, 6));
            1: o.entry_id = $urandom;
            2: o.entry_id = len > 0 ? ids[$urandom_range(len - 1)] : 32'd1;
            default: o.entry_id = k < 5 ? 32'd0 : ~32'($urandom_range(3));
        endcase
        return o;
    endfunction

    function automatic reply_t rp(logic ok, logic [2:0] st, logic [31:0] id,
                                  logic signed [8:0] c);
        reply_t r;
        r.ok = ok; r.status = st; r.result_id = id; r.cursor = c;
        return r;
    endfunction

    // result checker
    always @(posedge aclk) begin
        reply_t got, exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[0], m_tdata[3:1], m_tdata[35:4], m_tdata[44:36]};
            if (pending_replies.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected beat %h", got);
            end else begin
                exp_r = pending_replies.pop_front();
                if (got.ok !== exp_r.ok || got.status !== exp_r.status ||
                    got.result_id !== exp_r.result_id || got.cursor !== exp_r.cursor) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected ok=%0d st=%0d id=%h cur=%0d, got ok=%0d st=%0d id=%h cur=%0d",
                                 exp_r.ok, exp_r.status, exp_r.result_id, exp_r.cursor,
                                 got.ok, got.status, got.result_id, got.cursor);
                end
            end
        end
    end

    always @(negedge aclk) m_tready <= ($urandom_range(99) >= dst_idle);

    always @(posedge aclk) begin
        cycles++;
        if (cycles > 100000000) begin
            $display("ordered_id_list_with_cursor test failed");
            $finish;
        end
    end

    initial begin
        row_t rw;
        reply_t dummy;
        len = 0; cur = -1; rep_one = 0; rep_all = 0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed table: expected reply typed only where obvious
        rows = '{
            '{mk(OP_ADVANCE, 0, 0, 0, 0), 1, rp(0, ST_NOCUR, 0, -1)},
            '{mk(OP_CUR_ID, 0, 0, 0, 0), 1, rp(0, ST_NOCUR, 0, -1)},
            '{mk(OP_CUR_POS, 0, 0, 0, 0), 1, rp(0, ST_NOCUR, 0, -1)},
            '{mk(OP_APPEND, 0, 0, 0, 0), 1, rp(0, ST_ZERO, 0, -1)},
            '{mk(OP_INSERT, 1, 0, 0, 5), 1, rp(0, ST_RANGE, 0, -1)},
            '{mk(OP_READ_AT, 0, 0, 0, 0), 1, rp(0, ST_RANGE, 0, -1)},
            '{mk(OP_APPEND, 255, 255, 9'h0ff, 32'hffffffff), 0, dummy},
            '{mk(OP_INSERT, 0, 0, 0, 32'h1), 0, dummy},
            '{mk(OP_APPEND, 0, 0, 0, 32'h1), 0, dummy},
            '{mk(OP_CUR_ID, 0, 0, 0, 0), 1, rp(1, ST_OK, 32'h1, 0)},
            '{mk(OP_ADVANCE, 0, 0, 0, 0), 0, dummy},
            '{mk(OP_MOVE, 0, 2, 0, 0), 0, dummy},
            '{mk(OP_MOVE, 3, 0, 0, 0), 1, rp(0, ST_RANGE, 0, 0)},
            '{mk(OP_MOVE, 0, 255, 0, 0), 0, dummy},
            '{mk(OP_SET_POS, 255, 0, 0, 0), 0, dummy},
            '{mk(OP_SET_POS, 2, 0, 0, 0), 0, dummy},
            '{mk(OP_SET_REL, 0, 0, 9'h100, 0), 0, dummy},
            '{mk(OP_SET_REL, 0, 0, 9'h1fe, 0), 0, dummy},
            '{mk(OP_REMOVE, 0, 0, 0, 0), 0, dummy},
            '{mk(OP_REMOVE, 200, 0, 0, 0), 0, dummy},
            '{mk(OP_REMOVE_ID, 0, 0, 0, 32'h1), 0, dummy},
            '{mk(4'd12, 0, 0, 0, 0), 1, rp(0, ST_RANGE, 0, -1)},
            '{mk(4'd15, 8'hff, 8'hff, 9'h1ff, 32'hffffffff), 1, rp(0, ST_RANGE, 0, -1)},
            '{mk(OP_CLEAR, 0, 0, 0, 0), 1, rp(1, ST_OK, 0, -1)}
        };
        foreach (rows[i]) begin
            rw = rows[i];
            send_op(rw.op, rw.known, rw.want);
        end
        wait_drained();

        // fill to full, hit the full checks, then work on the full list and clear it
        for (int i = 0; i < LIST_DEPTH; i++) send_op(mk(OP_APPEND, 0, 0, 0, i + 1), 0, dummy);
        send_op(mk(OP_APPEND, 0, 0, 0, 7), 1, rp(0, ST_FULL, 0, -1));
        send_op(mk(OP_INSERT, 0, 0, 0, 7), 1, rp(0, ST_FULL, 0, -1));
        send_op(mk(OP_SET_POS, 255, 0, 0, 0), 0, dummy);
        send_op(mk(OP_MOVE, 255, 0, 0, 0), 0, dummy);
        send_op(mk(OP_REMOVE, 255, 0, 0, 0), 0, dummy);
        send_op(mk(OP_CLEAR, 0, 0, 0, 0), 0, dummy);
        wait_drained();

        for (int ph = 0; ph < 6; ph++) begin
            src_idle = ph < 2 ? 18 : (ph < 4 ? 79 : 0);
            dst_idle = ph < 2 ? 79 : (ph < 4 ? 18 : 0);
            write_reg(CFG_REPEAT_ONE, ph == 1 || ph == 5);
            write_reg(CFG_REPEAT_ALL, ph == 2 || ph == 5);
            for (int n = 0; n < 44; n++) begin
                if (len > 40 && $urandom_range(9) == 0)
                    send_op(mk(OP_CLEAR, 0, 0, 0, 0), 0, dummy);
                else send_op(rand_op(), 0, dummy);
                if (n == 22) wait_drained();
            end
            wait_drained();
        end

        if (errors == 0 && pending_replies.size() == 0)
            $display("ordered_id_list_with_cursor test passed");
        else
            $display("ordered_id_list_with_cursor test failed");
        $finish;
    end
endmodule
